FILE: rtl/lkc_pkg.sv
package lkc_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MODE          = 3'd0;
    localparam logic [2:0] REG_SHARD_VARIANT = 3'd1;
    localparam logic [2:0] REG_SEED_VALUE    = 3'd2;
    localparam logic [2:0] REG_SEED_SALT     = 3'd3;
    localparam logic [2:0] REG_KEY_CONST_ONE = 3'd4;
    localparam logic [2:0] REG_KEY_CONST_TWO = 3'd5;
    localparam logic [2:0] REG_KEY_CONST_THR = 3'd6;

    // Key update rules. Any other code runs the three-constant shift.
    localparam logic [1:0] MODE_THREE_CONST = 2'd0;
    localparam logic [1:0] MODE_TWO_CONST   = 2'd1;
    localparam logic [1:0] MODE_MULTIPLY    = 2'd2;
    localparam logic [1:0] MODE_SPARE       = 2'd3;

    // Input item kinds.
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_ENCRYPT = 1'b1;

    // Key derivation constants.
    localparam logic [31:0] SEED_LOW_MASK  = 32'hffffaaaa;
    localparam logic [31:0] SHARD_CONST_1  = 32'h12340000;
    localparam logic [31:0] SHARD_CONST_0  = 32'h43210000;
    localparam logic [31:0] SEED_HIGH_MIX  = 32'habcdffff;

    // Multiply rule constants.
    localparam logic [31:0] MUL_SQ_ONE  = 32'h35ce9581;
    localparam logic [31:0] MUL_ADD_ONE = 32'h07afcc37;
    localparam logic [31:0] MUL_SQ_ZERO = 32'h4c3a1353;
    localparam logic [31:0] MUL_ADD_ZERO = 32'h16ef783f;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 3;

    typedef struct packed {
        logic [1:0]  mode;
        logic        shard_variant;
        logic [31:0] seed_value;
        logic [31:0] seed_salt;
        logic [31:0] key_const_one;
        logic [31:0] key_const_two;
        logic [31:0] key_const_three;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic load;
    } cmd_t;

endpackage

FILE: rtl/lkc_mul.sv
// Shared 32 by 32 multiplier that keeps the low half of the product,
// with the result registered.
module lkc_mul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] prod
);

    logic [31:0] prod_reg;
    logic [31:0] prod_next;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/lkc_keyupd.sv
// Key state and its update sequencer. Derivation and the shift rules finish
// in the start cycle; the multiply rule runs eleven steps through the shared
// multiplier and one adder.
module lkc_keyupd
(
    input  logic          clk,
    input  logic          rst_n,
    input  lkc_pkg::cfg_t cfg,
    input  lkc_pkg::cmd_t cmd,
    output logic          done,
    output logic [7:0]    key_low
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [3:0] STEP_SHIFT_ONE = 4'd2;
    localparam logic [3:0] STEP_ACC_ONE   = 4'd3;
    localparam logic [3:0] STEP_KEY_ONE   = 4'd5;
    localparam logic [3:0] STEP_SHIFT_ZERO = 4'd7;
    localparam logic [3:0] STEP_ACC_ZERO  = 4'd8;
    localparam logic [3:0] STEP_LAST      = 4'd10;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic [31:0] key0_reg, key0_next;
    logic [31:0] key1_reg, key1_next;
    logic [31:0] acc_reg, acc_next;

    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] add_a, add_b, sum;
    logic [31:0] ns, shard_c, shift_a;
    logic [31:0] simple0, simple1;

    lkc_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Multiplier operands for each step of the multiply rule.
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (step_reg)
            4'd0:
            begin
                mul_a = key1_reg;
                mul_b = 32'd5;
            end
            4'd1:
            begin
                mul_a = prod;
                mul_b = key1_reg;
            end
            4'd2:
            begin
                mul_a = key1_reg;
                mul_b = cfg.key_const_one;
            end
            4'd3:
            begin
                mul_a = key0_reg;
                mul_b = key0_reg;
            end
            4'd4:
            begin
                mul_a = prod;
                mul_b = lkc_pkg::MUL_SQ_ONE;
            end
            4'd5:
            begin
                mul_a = key0_reg;
                mul_b = 32'd3;
            end
            4'd6:
            begin
                mul_a = prod;
                mul_b = key0_reg;
            end
            4'd7:
            begin
                mul_a = key0_reg;
                mul_b = cfg.key_const_two;
            end
            4'd8:
            begin
                mul_a = key1_reg;
                mul_b = key1_reg;
            end
            4'd9:
            begin
                mul_a = prod;
                mul_b = lkc_pkg::MUL_SQ_ZERO;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // The single adder either starts a sum with the shifted constant or adds
    // the last product to the running sum.
    always_comb
    begin
        priority if (step_reg == STEP_SHIFT_ONE)
        begin
            add_a = cfg.key_const_one >> prod[4:0];
            add_b = lkc_pkg::MUL_ADD_ONE;
        end
        else if (step_reg == STEP_SHIFT_ZERO)
        begin
            add_a = cfg.key_const_two >> prod[4:0];
            add_b = lkc_pkg::MUL_ADD_ZERO;
        end
        else
        begin
            add_a = acc_reg;
            add_b = prod;
        end
    end

    assign sum = add_a + add_b;

    assign ns = ~cfg.seed_value;
    assign shard_c = cfg.shard_variant ? lkc_pkg::SHARD_CONST_1 : lkc_pkg::SHARD_CONST_0;

    // Shift rules; the first rotated word is shared by both.
    assign shift_a = {key0_reg[0], key1_reg[31:1]} ^ cfg.key_const_one;
    always_comb
    begin
        if (cfg.mode == lkc_pkg::MODE_TWO_CONST)
        begin
            simple0 = {key1_reg[0], key0_reg[31:1]} ^ cfg.key_const_two;
            simple1 = shift_a;
        end
        else
        begin
            simple0 = {key1_reg[0], key0_reg[31:1]} ^ cfg.key_const_three;
            simple1 = {key0_reg[0], shift_a[31:1]} ^ cfg.key_const_two;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        key0_next  = key0_reg;
        key1_next  = key1_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    if (cmd.load)
                    begin
                        key0_next = {(ns[15:0] ^ cfg.seed_salt[15:0]),
                                     (cfg.seed_value[15:0] ^ lkc_pkg::SEED_LOW_MASK[15:0])};
                        key1_next = {(ns[31:16] ^ lkc_pkg::SEED_HIGH_MIX[31:16]),
                                     (cfg.seed_value[31:16] ^ shard_c[31:16])};
                        state_next = ST_FIN;
                    end
                    else if (cfg.mode == lkc_pkg::MODE_MULTIPLY)
                    begin
                        step_next  = 4'd0;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        key0_next  = simple0;
                        key1_next  = simple1;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MUL:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == STEP_SHIFT_ONE || step_reg == STEP_ACC_ONE ||
                    step_reg == STEP_SHIFT_ZERO || step_reg == STEP_ACC_ZERO)
                begin
                    acc_next = sum;
                end
                if (step_reg == STEP_KEY_ONE)
                begin
                    key1_next = sum;
                end
                if (step_reg == STEP_LAST)
                begin
                    key0_next  = sum;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 4'd0;
            key0_reg  <= 32'd0;
            key1_reg  <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            key0_reg  <= key0_next;
            key1_reg  <= key1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign done    = (state_reg == ST_FIN);
    assign key_low = key0_reg[7:0];

endmodule

FILE: rtl/login_keystream_cipher.sv
// Byte stream cipher with a 64-bit key state kept as two 32-bit words. A load
// item (kind 0) derives both key words from the seed registers and gives no
// result. An encrypt item (kind 1) returns its byte XORed with the low byte of
// key word zero, with last_in copied to last_out, and then advances the key
// state by the rule in the mode register. In the multiply mode the update
// needs ten dependent 32-bit products, and they go one per cycle through a
// single shared multiplier under a step counter, with one adder summing the
// terms. The block takes one item at a time; the result sits in an output
// register, and the next item is accepted while it still waits to be taken.
// Only if that item produces its own result before the first one is gone
// does the block hold until the output register frees up. Configuration is a
// plain write port and must only be written while the block is idle.
module login_keystream_cipher
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_write,
    input  logic [lkc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lkc_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             kind,
    input  logic [7:0]                       data_byte,
    input  logic                             last_in,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       cipher_byte,
    output logic                             last_out
);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_RUN  = 2'd1;
    localparam logic [1:0] T_EMIT = 2'd2;

    lkc_pkg::cfg_t cfg_reg;
    lkc_pkg::cmd_t cmd;

    logic [1:0] state_reg, state_next;
    logic       in_accept;
    logic       out_free;
    logic       upd_done;
    logic [7:0] key_low;

    // The pending result is formed at acceptance, from the key before update.
    logic       pend_has_reg;
    logic [7:0] pend_byte_reg;
    logic       pend_last_reg;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] cipher_byte_reg;
    logic       last_out_reg;
    logic       out_load;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lkc_pkg::REG_MODE:          cfg_reg.mode <= cfg_data[1:0];
                lkc_pkg::REG_SHARD_VARIANT: cfg_reg.shard_variant <= cfg_data[0];
                lkc_pkg::REG_SEED_VALUE:    cfg_reg.seed_value <= cfg_data[31:0];
                lkc_pkg::REG_SEED_SALT:     cfg_reg.seed_salt <= cfg_data[31:0];
                lkc_pkg::REG_KEY_CONST_ONE: cfg_reg.key_const_one <= cfg_data[31:0];
                lkc_pkg::REG_KEY_CONST_TWO: cfg_reg.key_const_two <= cfg_data[31:0];
                lkc_pkg::REG_KEY_CONST_THR: cfg_reg.key_const_three <= cfg_data[31:0];
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_stall  = (state_reg != T_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign cmd.start = in_accept;
    assign cmd.load  = (kind == lkc_pkg::KIND_LOAD);

    lkc_keyupd u_keyupd
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .done    (upd_done),
        .key_low (key_low)
    );

    // Item control: run the key update, then hand an encrypt result to the output
    // register, waiting there only while the output register is still full.
    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = T_RUN;
                end
            end
            T_RUN:
            begin
                if (upd_done)
                begin
                    if (!pend_has_reg)
                    begin
                        state_next = T_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = T_IDLE;
                    end
                    else
                    begin
                        state_next = T_EMIT;
                    end
                end
            end
            T_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            pend_has_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                pend_has_reg <= (kind == lkc_pkg::KIND_ENCRYPT);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pend_byte_reg <= data_byte ^ key_low;
            pend_last_reg <= last_in;
        end
        if (out_load)
        begin
            cipher_byte_reg <= pend_byte_reg;
            last_out_reg    <= pend_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cipher_byte = cipher_byte_reg;
    assign last_out    = last_out_reg;

endmodule
